/* src/sws_pkg.sv */
package sws_pkg;

    // Default geometry
    localparam int SEQ_SPACE_DEF    = 8;
    localparam int PAYLOAD_BITS_DEF = 64;

    // Fixed field widths of the stream items
    localparam int CMD_W     = 2;
    localparam int SEQ_W     = 3;
    localparam int PAY_W     = 64;
    localparam int WIN_W     = 3;
    localparam int TACT_W    = 2;
    localparam int IN_DATA_W = 72;
    localparam int OUT_DATA_W = 80;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 3'd4;

    // Duplicate ACKs that trigger a fast retransmit
    localparam logic [1:0] DUP_LIMIT = 2'd3;

    typedef enum logic [CMD_W-1:0] {
        CMD_SEND    = 2'd0,
        CMD_ACK     = 2'd1,
        CMD_TIMEOUT = 2'd2
    } t_cmd;

    typedef enum logic [TACT_W-1:0] {
        TMR_NONE    = 2'd0,
        TMR_START   = 2'd1,
        TMR_STOP    = 2'd2,
        TMR_RESTART = 2'd3
    } t_timer;

endpackage

/* src/sws_store.sv */
// Packet store: one write port, one read port with registered read data.
module sws_store #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 64,
    parameter int AW    = 3
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, data held while the read enable is low
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/sliding_window_sender_unit.sv */
// Sliding-window sender with cumulative ACKs and fast retransmit. Each transfer on the
// slave stream is one event (tuser: 0 send, 1 ack, 2 timeout) and yields exactly one
// result transfer on the master stream. The unit takes one event per clock while the
// output is not stalled: an event is held in the input register, where the window checks,
// the duplicate counters and the packet store address are worked out, and then lands in
// the result register. The packet store is a single memory with one write and one
// registered read port; a send writes it, a fast retransmit or timeout reads it. The user
// must write window_size through i_cfg_we/i_cfg_wdata only while the unit is idle; the
// unit does not enforce this. window_size resets to 4; it is clamped to SEQ_SPACE-1 and
// a value of zero refuses every send.
module sliding_window_sender_unit
    import sws_pkg::*;
#(
    parameter int SEQ_SPACE    = SEQ_SPACE_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [WIN_W-1:0]      i_cfg_wdata,     // window_size
    // event stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [63:0] payload, [66:64] seq_number, [67] ack_checksum_ok, [71:68] zero
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // [1:0] cmd
    input  logic [CMD_W-1:0]      i_s_axis_tuser,
    // result stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [0] accepted, [1] transmit, [4:2] tx_seq, [68:5] tx_payload,
    // [70:69] timer_action, [73:71] timer_seq, [74] window_full, [79:75] zero
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    localparam int SW = $clog2(SEQ_SPACE);
    localparam int CW = SW + WIN_W;
    localparam logic [SW-1:0] SEQ_MAX = SW'(SEQ_SPACE - 1);

    // modular helpers on sequence numbers
    function automatic logic [SW-1:0] seq_inc(input logic [SW-1:0] a);
        return (a == SEQ_MAX) ? '0 : a + SW'(1);
    endfunction

    function automatic logic [SW-1:0] seq_sub(input logic [SW-1:0] a, input logic [SW-1:0] b);
        return (a >= b) ? a - b : a - b + SW'(SEQ_SPACE);
    endfunction

    function automatic logic [SW-1:0] seq_reduce(input logic [SEQ_W-1:0] s);
        logic [SEQ_W:0] v;
        v = {1'b0, s};
        for (int k = 0; k < 3; k++) begin
            if (int'(v) >= SEQ_SPACE) begin
                v = v - (SEQ_W+1)'(SEQ_SPACE);
            end
        end
        return SW'(v);
    endfunction

    // state
    logic [WIN_W-1:0]        r_window;
    logic [SW-1:0]           r_base;
    logic [SW-1:0]           r_next;
    logic [1:0]              r_dup [SEQ_SPACE];

    // input register
    logic                    r_in_valid;
    logic [CMD_W-1:0]        r_in_cmd;
    logic [PAYLOAD_BITS-1:0] r_in_pay;
    logic [SEQ_W-1:0]        r_in_seq;
    logic                    r_in_ck;

    // result register
    logic                    r_out_valid;
    logic                    r_out_accepted;
    logic                    r_out_transmit;
    logic [SEQ_W-1:0]        r_out_tx_seq;
    logic                    r_out_from_store;
    logic [PAYLOAD_BITS-1:0] r_out_pay;
    t_timer                  r_out_tact;
    logic [SEQ_W-1:0]        r_out_tseq;
    logic                    r_out_full;

    // next values
    logic [SW-1:0]           n_base;
    logic [SW-1:0]           n_next;
    logic                    n_accepted;
    logic                    n_transmit;
    logic [SW-1:0]           n_tx_seq;
    logic                    n_from_store;
    t_timer                  n_tact;
    logic [SW-1:0]           n_tseq;
    logic                    n_full;
    logic                    n_dup_we;
    logic                    n_dup_clr;
    logic [1:0]              n_dup_cnt;

    logic                    w_move;
    logic                    w_store_we;
    logic [SW-1:0]           w_rd_addr;
    logic [PAYLOAD_BITS-1:0] w_rd_data;
    logic [SW-1:0]           w_num;
    logic [SW-1:0]           w_in_flight;
    logic [CW-1:0]           w_eff_win;
    logic                    w_full_now;
    logic                    w_dup_any;

    // handshakes: the input stage advances when the result register is free or drains
    assign w_move          = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_move;
    assign o_m_axis_tvalid = r_out_valid;

    // window occupancy before this event
    assign w_num       = seq_reduce(r_in_seq);
    assign w_in_flight = seq_sub(r_next, r_base);
    assign w_eff_win   = (CW'(r_window) > CW'(SEQ_SPACE - 1)) ? CW'(SEQ_SPACE - 1)
                                                               : CW'(r_window);
    assign w_full_now  = CW'(w_in_flight) >= w_eff_win;

    // event decode
    always_comb begin
        n_base       = r_base;
        n_next       = r_next;
        n_accepted   = 1'b0;
        n_transmit   = 1'b0;
        n_tx_seq     = '0;
        n_from_store = 1'b0;
        n_tact       = TMR_NONE;
        n_tseq       = '0;
        n_dup_we     = 1'b0;
        n_dup_clr    = 1'b0;
        n_dup_cnt    = r_dup[w_num] + 2'd1;
        w_store_we   = 1'b0;
        w_rd_addr    = r_base;
        case (t_cmd'(r_in_cmd))
            CMD_SEND: begin
                if (!w_full_now) begin
                    w_store_we = w_move;
                    n_accepted = 1'b1;
                    n_transmit = 1'b1;
                    n_tx_seq   = r_next;
                    if (r_base == r_next) begin
                        n_tact = TMR_START;
                        n_tseq = r_next;
                    end
                    n_next = seq_inc(r_next);
                end
            end
            CMD_ACK: begin
                if (r_in_ck) begin
                    if (seq_sub(w_num, r_base) < w_in_flight) begin
                        // cumulative ACK slides the base
                        n_base = seq_inc(w_num);
                        n_tact = (n_base == r_next) ? TMR_STOP : TMR_RESTART;
                        n_tseq = n_base;
                    end else if (n_dup_cnt == DUP_LIMIT) begin
                        // fast retransmit of the packet after the duplicate number
                        n_transmit   = 1'b1;
                        n_tx_seq     = seq_inc(w_num);
                        n_from_store = 1'b1;
                        w_rd_addr    = seq_inc(w_num);
                        n_dup_clr    = 1'b1;
                    end else begin
                        n_dup_we = 1'b1;
                    end
                end
            end
            CMD_TIMEOUT: begin
                if (r_base != r_next) begin
                    n_transmit   = 1'b1;
                    n_tx_seq     = r_base;
                    n_from_store = 1'b1;
                    n_tact       = TMR_RESTART;
                    n_tseq       = w_num;
                    n_dup_clr    = 1'b1;
                end
            end
            default: begin
            end
        endcase
        n_full = CW'(seq_sub(n_next, n_base)) >= w_eff_win;
    end

    // control state and result flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= WINDOW_RESET;
            r_base      <= '0;
            r_next      <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < SEQ_SPACE; i++) begin
                r_dup[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
            end
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (w_move) begin
                r_out_valid <= 1'b1;
                r_base      <= n_base;
                r_next      <= n_next;
                if (n_dup_clr) begin
                    for (int i = 0; i < SEQ_SPACE; i++) begin
                        r_dup[i] <= '0;
                    end
                end else if (n_dup_we) begin
                    r_dup[w_num] <= n_dup_cnt;
                end
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_cmd <= i_s_axis_tuser;
            r_in_pay <= PAYLOAD_BITS'(i_s_axis_tdata[PAY_W-1:0]);
            r_in_seq <= i_s_axis_tdata[PAY_W +: SEQ_W];
            r_in_ck  <= i_s_axis_tdata[PAY_W + SEQ_W];
        end
        if (w_move) begin
            r_out_accepted   <= n_accepted;
            r_out_transmit   <= n_transmit;
            r_out_tx_seq     <= SEQ_W'(n_tx_seq);
            r_out_from_store <= n_from_store;
            r_out_pay        <= n_accepted ? r_in_pay : '0;
            r_out_tact       <= n_tact;
            r_out_tseq       <= SEQ_W'(n_tseq);
            r_out_full       <= n_full;
        end
    end

    // packet store, read data lines up with the result register
    sws_store #(
        .DEPTH (SEQ_SPACE),
        .WIDTH (PAYLOAD_BITS),
        .AW    (SW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_store_we),
        .i_wr_addr (r_next),
        .i_wr_data (r_in_pay),
        .i_rd_en   (w_move),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // result packing
    assign o_m_axis_tdata = {
        (OUT_DATA_W - 75)'(0),
        r_out_full,
        r_out_tseq,
        r_out_tact,
        PAY_W'(r_out_from_store ? w_rd_data : r_out_pay),
        r_out_tx_seq,
        r_out_transmit,
        r_out_accepted
    };

    // any duplicate counter nonzero
    always_comb begin
        w_dup_any = 1'b0;
        for (int i = 0; i < SEQ_SPACE; i++) begin
            w_dup_any = w_dup_any | (r_dup[i] != 2'd0);
        end
    end

`ifndef SYNTHESIS
    a_accept_sends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_accepted) |-> (r_out_transmit && !r_out_from_store))
        else $error("accepted send without a direct transmit");

    a_start_on_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_tact == TMR_START) |-> r_out_accepted)
        else $error("timer start without an accepted send");

    a_timeout_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_move && r_in_cmd == CMD_TIMEOUT && r_base != r_next) |=> !w_dup_any)
        else $error("duplicate counters not cleared after timeout resend");

    a_next_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_move && n_accepted) |=> (r_next != $past(r_next)))
        else $error("next sequence number did not advance on an accepted send");
`endif

endmodule

/* tb/sliding_window_sender_unit_tb.sv */
module sliding_window_sender_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sws_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
    localparam int               NUM_SEQS    = SEQ_SPACE_DEF;

    // one event as it travels on the slave stream
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [PAY_W-1:0] payload;
        logic [SEQ_W-1:0] seq;
        logic             ck_ok;
    } t_sw_event;

    // one result as it travels on the master stream
    typedef struct packed {
        logic              accepted;
        logic              transmit;
        logic [SEQ_W-1:0]  tx_seq;
        logic [PAY_W-1:0]  tx_payload;
        logic [TACT_W-1:0] timer_action;
        logic [SEQ_W-1:0]  timer_seq;
        logic              window_full;
    } t_sw_result;

    // sender state plus the window register
    typedef struct packed {
        logic [WIN_W-1:0]                 win;
        logic [SEQ_W-1:0]                 base;
        logic [SEQ_W-1:0]                 nxt;
        logic [NUM_SEQS-1:0][PAY_W-1:0]   store;
        logic [NUM_SEQS-1:0][1:0]         dups;
        logic [NUM_SEQS-1:0]              written;
    } t_sender_state;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [WIN_W-1:0]      i_cfg_wdata = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic [CMD_W-1:0]      i_s_axis_tuser = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;

    t_sw_event     pending_events[$];
    t_sw_result    expected_results[$];
    t_sw_event     cur_ev;
    t_sender_state model_st;   // advanced on each accepted transfer
    t_sender_state plan_st;    // advanced as events are queued
    int            snd_idle_pct = 0;
    int            rcv_idle_pct = 0;
    int            fail_count = 0;
    int            n_checked = 0;
    int            n_taken = 0;
    int            n_resent = 0;

    sliding_window_sender_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    // next state and result of the sender for one event
    function automatic void sender_advance(input t_sender_state s, input t_sw_event ev,
                                           output t_sender_state ns, output t_sw_result r);
        logic [SEQ_W-1:0] in_flight;
        logic [SEQ_W-1:0] offset;
        logic [SEQ_W-1:0] resend;
        ns = s;
        r = '0;
        in_flight = s.nxt - s.base;
        case (ev.cmd)
            CMD_SEND: begin
                if (in_flight < s.win) begin
                    ns.store[s.nxt] = ev.payload;
                    ns.written[s.nxt] = 1'b1;
                    r.accepted = 1'b1;
                    r.transmit = 1'b1;
                    r.tx_seq = s.nxt;
                    r.tx_payload = ev.payload;
                    // first packet in an empty window starts the timer
                    if (s.base == s.nxt) begin
                        r.timer_action = TMR_START;
                        r.timer_seq = s.nxt;
                    end
                    ns.nxt = s.nxt + 1'b1;
                end
            end
            CMD_ACK: begin
                if (ev.ck_ok) begin
                    offset = ev.seq - s.base;
                    if (offset < in_flight) begin
                        // cumulative ack slides the base
                        ns.base = ev.seq + 1'b1;
                        r.timer_action = (ns.base == s.nxt) ? TMR_STOP : TMR_RESTART;
                        r.timer_seq = ns.base;
                    end else begin
                        ns.dups[ev.seq] = s.dups[ev.seq] + 1'b1;
                        if (ns.dups[ev.seq] == DUP_LIMIT) begin
                            resend = ev.seq + 1'b1;
                            r.transmit = 1'b1;
                            r.tx_seq = resend;
                            r.tx_payload = s.store[resend];
                            ns.dups = '0;
                        end
                    end
                end
            end
            CMD_TIMEOUT: begin
                if (s.base != s.nxt) begin
                    r.transmit = 1'b1;
                    r.tx_seq = s.base;
                    r.tx_payload = s.store[s.base];
                    r.timer_action = TMR_RESTART;
                    r.timer_seq = ev.seq;
                    ns.dups = '0;
                end
            end
            default: ;
        endcase
        in_flight = ns.nxt - ns.base;
        r.window_full = (in_flight >= ns.win);
    endfunction

    function automatic t_sw_event mk_event(input logic [CMD_W-1:0] cmd,
                                           input logic [PAY_W-1:0] payload,
                                           input logic [SEQ_W-1:0] seq, input logic ck_ok);
        t_sw_event ev;
        ev.cmd = cmd;
        ev.payload = payload;
        ev.seq = seq;
        ev.ck_ok = ck_ok;
        return ev;
    endfunction

    // queue an event; a fast retransmit of a never-sent number gets a bad checksum instead
    task automatic queue_event(input t_sw_event ev);
        t_sender_state ns;
        t_sw_result    r;
        sender_advance(plan_st, ev, ns, r);
        if (ev.cmd == CMD_ACK && r.transmit && !plan_st.written[r.tx_seq]) begin
            ev.ck_ok = 1'b0;
            sender_advance(plan_st, ev, ns, r);
        end
        plan_st = ns;
        pending_events.push_back(ev);
    endtask

    // mostly protocol-like traffic with random content, some noise
    task automatic queue_random(input int n_events);
        t_sw_event        ev;
        int               pick;
        int               count;
        logic [SEQ_W-1:0] span;
        count = 0;
        while (count < n_events) begin
            pick = $urandom_range(0, 99);
            span = plan_st.nxt - plan_st.base;
            ev.payload = {$urandom(), $urandom()};
            ev.seq = SEQ_W'($urandom_range(0, NUM_SEQS - 1));
            ev.ck_ok = 1'b1;
            if (pick < 40) begin
                ev.cmd = CMD_SEND;
                if ($urandom_range(0, 9) == 0)
                    ev.payload = $urandom_range(0, 1) ? {PAY_W{1'b1}} : {PAY_W{1'b0}};
                queue_event(ev);
                count++;
            end else if (pick < 68) begin
                ev.cmd = CMD_ACK;
                if (span != 0 && $urandom_range(0, 3) != 0)
                    ev.seq = SEQ_W'(plan_st.base + $urandom_range(0, span - 1));
                ev.ck_ok = ($urandom_range(0, 9) != 0);
                queue_event(ev);
                count++;
            end else if (pick < 78) begin
                // burst of duplicates of the last acked number
                ev.cmd = CMD_ACK;
                ev.seq = plan_st.base - 1'b1;
                repeat (3) queue_event(ev);
                count += 3;
            end else if (pick < 88) begin
                ev.cmd = CMD_TIMEOUT;
                if ($urandom_range(0, 3) != 0)
                    ev.seq = plan_st.base;
                queue_event(ev);
                count++;
            end else if (pick < 92) begin
                ev.cmd = CMD_UNKNOWN;
                ev.ck_ok = 1'($urandom_range(0, 1));
                queue_event(ev);
                count++;
            end else begin
                ev.cmd = CMD_W'($urandom_range(0, 3));
                ev.ck_ok = 1'($urandom_range(0, 1));
                queue_event(ev);
                count++;
            end
        end
    endtask

    task automatic wait_idle();
        while (pending_events.size() != 0 || i_s_axis_tvalid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic void check_field(input string name, input logic [PAY_W-1:0] want,
                                        input logic [PAY_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    // event driver: predicts each transfer, then loads the next event
    always @(posedge i_clk) begin : drive_events
        t_sender_state nxt_st;
        t_sw_result    res;
        t_sw_event     nxt_ev;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                sender_advance(model_st, cur_ev, nxt_st, res);
                model_st = nxt_st;
                expected_results.push_back(res);
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (pending_events.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
                    nxt_ev = pending_events.pop_front();
                    cur_ev <= nxt_ev;
                    i_s_axis_tdata <= {4'b0, nxt_ev.ck_ok, nxt_ev.seq, nxt_ev.payload};
                    i_s_axis_tuser <= nxt_ev.cmd;
                    i_s_axis_tvalid <= 1'b1;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor: compares each transfer with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_sw_result want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result transfer: 0x%0h", o_m_axis_tdata);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("accepted", PAY_W'(want.accepted),
                                PAY_W'(o_m_axis_tdata[0]));
                    check_field("transmit", PAY_W'(want.transmit),
                                PAY_W'(o_m_axis_tdata[1]));
                    check_field("tx_seq", PAY_W'(want.tx_seq),
                                PAY_W'(o_m_axis_tdata[4:2]));
                    check_field("tx_payload", want.tx_payload, o_m_axis_tdata[68:5]);
                    check_field("timer_action", PAY_W'(want.timer_action),
                                PAY_W'(o_m_axis_tdata[70:69]));
                    check_field("timer_seq", PAY_W'(want.timer_seq),
                                PAY_W'(o_m_axis_tdata[73:71]));
                    check_field("window_full", PAY_W'(want.window_full),
                                PAY_W'(o_m_axis_tdata[74]));
                    n_checked++;
                    n_taken += int'(want.accepted);
                    if (want.transmit && !want.accepted)
                        n_resent++;
                end
            end
            i_m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    // stimulus: directed sequence at the reset window, then one random phase per setting
    initial begin : stimulus
        int unsigned win_plan[8];
        win_plan = '{1, 7, 0, 3, 5, 2, 6, 4};
        model_st = '0;
        model_st.win = WINDOW_RESET;
        plan_st = model_st;
        snd_idle_pct = 12;
        rcv_idle_pct = 54;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty window: timeout ignored, bad and duplicate acks, unknown command
        queue_event(mk_event(CMD_TIMEOUT, '0, 3'd5, 1'b1));
        queue_event(mk_event(CMD_ACK, '0, 3'd2, 1'b0));
        queue_event(mk_event(CMD_ACK, '0, 3'd6, 1'b1));
        queue_event(mk_event(CMD_UNKNOWN, {PAY_W{1'b1}}, 3'd7, 1'b1));
        // fill the window, then one refused send
        queue_event(mk_event(CMD_SEND, '0, 3'd0, 1'b0));
        queue_event(mk_event(CMD_SEND, {PAY_W{1'b1}}, 3'd7, 1'b1));
        queue_event(mk_event(CMD_SEND, 64'hA5A5_A5A5_A5A5_A5A5, 3'd0, 1'b0));
        queue_event(mk_event(CMD_SEND, 64'h5A5A_5A5A_5A5A_5A5A, 3'd0, 1'b0));
        queue_event(mk_event(CMD_SEND, 64'h0000_0000_0000_1234, 3'd0, 1'b0));
        // acks, timeout, fast retransmit, window drained
        queue_event(mk_event(CMD_ACK, '0, 3'd1, 1'b0));
        queue_event(mk_event(CMD_ACK, '0, 3'd0, 1'b1));
        queue_event(mk_event(CMD_TIMEOUT, '0, 3'd7, 1'b0));
        repeat (3) queue_event(mk_event(CMD_ACK, '0, 3'd0, 1'b1));
        queue_event(mk_event(CMD_ACK, '0, 3'd3, 1'b1));
        queue_event(mk_event(CMD_TIMEOUT, '0, 3'd0, 1'b1));
        queue_event(mk_event(CMD_UNKNOWN, '0, 3'd0, 1'b0));
        wait_idle();

        for (int p = 0; p < 8; p++) begin
            // window register written only while the unit is idle
            @(posedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_wdata <= WIN_W'(win_plan[p]);
            @(posedge i_clk);
            i_cfg_we <= 1'b0;
            model_st.win = WIN_W'(win_plan[p]);
            plan_st.win = WIN_W'(win_plan[p]);
            if (p < 3) begin
                snd_idle_pct = 12;
                rcv_idle_pct = 54;
            end else if (p < 6) begin
                snd_idle_pct = 54;
                rcv_idle_pct = 12;
            end else begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            queue_random(win_plan[p] == 0 ? 40 : 155);
            wait_idle();
        end

        repeat (10) @(posedge i_clk);
        $display("window settings 4,1,7,0,3,5,2,6,4 with send/ack/timeout traffic and stalls");
        $display("%0d results checked: %0d sends taken, %0d resends, %0d mismatches",
                 n_checked, n_taken, n_resent, fail_count);
        if (fail_count == 0) begin
            $display("sliding_window_sender_unit_tb passed");
        end else begin
            $display("sliding_window_sender_unit_tb failed");
        end
        $finish;
    end

    // run limit
    initial begin
        #400000;
        $display("sliding_window_sender_unit_tb failed");
        $finish;
    end

endmodule
